// ===== hdl/vlq_source_map_line_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// VLQ source-map line decoder assertion macros
// Property shorthands on the block clock with reset as the disable condition.
// ----------------------------------------------------------------------------
`ifndef VLQ_SOURCE_MAP_LINE_DECODER_MACROS_SVH
`define VLQ_SOURCE_MAP_LINE_DECODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VLQSM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VLQSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/vlqsm_pkg.sv =====
// ----------------------------------------------------------------------------
// VLQ source-map decoder package
// Token type passed from the character classifier to the field decoder.
// ----------------------------------------------------------------------------
package vlqsm_pkg;

	localparam int unsigned DIGIT_W = 6;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned SHIFT_W = 6;
	localparam int unsigned FIELD_W = 3;
	localparam logic [SHIFT_W-1:0] SHIFT_STEP = 6'd5;

	typedef enum logic [2:0] {
		TOK_DIGIT = 3'd0,
		TOK_COMMA = 3'd1,
		TOK_SEMI  = 3'd2,
		TOK_BAD   = 3'd3,
		TOK_END   = 3'd4
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t          kind;
		logic [DIGIT_W-1:0] digit;
	} token_t;

endpackage

// ===== hdl/vlqsm_front.sv =====
// ----------------------------------------------------------------------------
// VLQ source-map decoder front end
// Classifies each byte into a base64 digit, separator, bad byte or end marker.
// ----------------------------------------------------------------------------
module vlqsm_front (
	input  logic            func,
	input  logic [7:0]      character,
	output vlqsm_pkg::token_t tok
);
	import vlqsm_pkg::*;

	localparam logic [7:0] CHAR_SEMI  = 8'h3B;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;

	logic [7:0] value;

	always_comb begin
		value = 8'd0;
		tok.kind = TOK_BAD;
		case (character) inside
			[8'h41:8'h5A]: begin
				value = character - 8'h41;
				tok.kind = TOK_DIGIT;
			end
			[8'h61:8'h7A]: begin
				value = character - 8'd71;
				tok.kind = TOK_DIGIT;
			end
			[8'h30:8'h39]: begin
				value = character + 8'd4;
				tok.kind = TOK_DIGIT;
			end
			CHAR_PLUS: begin
				value = 8'd62;
				tok.kind = TOK_DIGIT;
			end
			CHAR_SLASH: begin
				value = 8'd63;
				tok.kind = TOK_DIGIT;
			end
			CHAR_SEMI: begin
				tok.kind = TOK_SEMI;
			end
			CHAR_COMMA: begin
				tok.kind = TOK_COMMA;
			end
			default: begin
				tok.kind = TOK_BAD;
			end
		endcase
		if (func) begin
			tok.kind = TOK_END;
		end
		tok.digit = value[DIGIT_W-1:0];
	end

endmodule

// ===== hdl/vlqsm_queue.sv =====
// ----------------------------------------------------------------------------
// VLQ source-map decoder token queue
// Small first-in first-out buffer between the classifier and the decoder.
// ----------------------------------------------------------------------------
module vlqsm_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  vlqsm_pkg::token_t          push_data,
	output logic                       full,
	input  logic                       pop,
	output logic                       pop_valid,
	output vlqsm_pkg::token_t          pop_data,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	import vlqsm_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	token_t            entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

endmodule

// ===== hdl/vlqsm_back.sv =====
// ----------------------------------------------------------------------------
// VLQ source-map decoder back end
// Assembles VLQ fields, tracks segments and the running source line, and
// holds the result register toward the output channel.
// ----------------------------------------------------------------------------
module vlqsm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tok_valid,
	input  vlqsm_pkg::token_t tok,
	output logic              tok_pop,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [31:0]       source_line,
	output logic              error,
	output logic              last
);
	import vlqsm_pkg::*;

	logic                failed_q;
	logic [VALUE_W-1:0]  acc_q;
	logic [SHIFT_W-1:0]  shift_q;
	logic                cont_q;
	logic [FIELD_W-1:0]  fields_q;
	logic [VALUE_W-1:0]  run_q;
	logic [VALUE_W-1:0]  run_p1_q;
	logic [VALUE_W-1:0]  first_q;
	logic                has_first_q;
	logic                add_pend_q;
	logic [VALUE_W-1:0]  delta_q;

	logic                out_valid_q;
	logic [VALUE_W-1:0]  line_q;
	logic                error_q;
	logic                last_q;

	logic [VALUE_W-1:0]  acc_next;
	logic [SHIFT_W-1:0]  shift_next;
	logic [FIELD_W-1:0]  fields_inc;
	logic [VALUE_W-1:0]  mag;
	logic [VALUE_W-1:0]  delta_next;
	logic [VALUE_W-1:0]  run_sum;
	logic [VALUE_W-1:0]  run_sum_p1;
	logic [VALUE_W-1:0]  run_eff;
	logic [VALUE_W-1:0]  run_p1_eff;
	logic                end_err;
	logic                mid_segment;

	assign tok_pop     = tok_valid && (!out_valid_q || !out_stall);
	assign out_valid   = out_valid_q;
	assign source_line = line_q;
	assign error       = error_q;
	assign last        = last_q;

	always_comb begin
		acc_next   = acc_q;
		shift_next = shift_q;
		if (!shift_q[SHIFT_W-1]) begin
			acc_next   = acc_q | (VALUE_W'(tok.digit[DIGIT_W-2:0]) << shift_q[SHIFT_W-2:0]);
			shift_next = shift_q + SHIFT_STEP;
		end
		mag        = acc_next >> 1;
		delta_next = acc_next[0] ? (~mag + VALUE_W'(1)) : mag;
		fields_inc = fields_q + FIELD_W'(1);
		run_sum    = run_q + delta_q;
		run_sum_p1 = run_q + delta_q + VALUE_W'(1);
		run_eff    = add_pend_q ? run_sum : run_q;
		run_p1_eff = add_pend_q ? run_sum_p1 : run_p1_q;
		mid_segment = (fields_q == FIELD_W'(2)) || (fields_q == FIELD_W'(3));
		end_err    = failed_q || cont_q || mid_segment;
	end

	always_ff @(posedge clk) begin
		if (tok_pop && !failed_q && tok.kind == TOK_DIGIT && !tok.digit[DIGIT_W-1]
				&& fields_inc == FIELD_W'(3)) begin
			delta_q <= delta_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			failed_q    <= 1'b0;
			acc_q       <= '0;
			shift_q     <= '0;
			cont_q      <= 1'b0;
			fields_q    <= '0;
			run_q       <= '0;
			run_p1_q    <= VALUE_W'(1);
			first_q     <= '0;
			has_first_q <= 1'b0;
			add_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
			line_q      <= '0;
			error_q     <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			add_pend_q <= 1'b0;
			run_q      <= run_eff;
			run_p1_q   <= run_p1_eff;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (tok_pop) begin
				if (tok.kind == TOK_END) begin
					out_valid_q <= 1'b1;
					error_q     <= end_err;
					last_q      <= 1'b1;
					line_q      <= (!end_err && has_first_q) ? first_q : '0;
					failed_q    <= 1'b0;
					acc_q       <= '0;
					shift_q     <= '0;
					cont_q      <= 1'b0;
					fields_q    <= '0;
					run_q       <= '0;
					run_p1_q    <= VALUE_W'(1);
					first_q     <= '0;
					has_first_q <= 1'b0;
				end else if (!failed_q) begin
					if (cont_q || tok.kind == TOK_DIGIT) begin
						if (tok.kind != TOK_DIGIT) begin
							failed_q <= 1'b1;
						end else begin
							cont_q <= tok.digit[DIGIT_W-1];
							if (tok.digit[DIGIT_W-1]) begin
								acc_q   <= acc_next;
								shift_q <= shift_next;
							end else begin
								acc_q    <= '0;
								shift_q  <= '0;
								fields_q <= (fields_inc >= FIELD_W'(5)) ? '0 : fields_inc;
								if (fields_inc == FIELD_W'(3)) begin
									add_pend_q <= 1'b1;
								end
								if (fields_inc == FIELD_W'(4) && !has_first_q
										&& !run_eff[VALUE_W-1]) begin
									first_q     <= run_p1_eff;
									has_first_q <= 1'b1;
								end
							end
						end
					end else begin
						case (tok.kind)
							TOK_COMMA, TOK_SEMI: begin
								if (mid_segment) begin
									failed_q <= 1'b1;
								end else begin
									fields_q <= '0;
									if (tok.kind == TOK_SEMI) begin
										out_valid_q <= 1'b1;
										error_q     <= 1'b0;
										last_q      <= 1'b0;
										line_q      <= has_first_q ? first_q : '0;
										has_first_q <= 1'b0;
										first_q     <= '0;
									end
								end
							end
							default: begin
								failed_q <= 1'b1;
							end
						endcase
					end
				end
			end
		end
	end

endmodule

// ===== hdl/vlq_source_map_line_decoder.sv =====
// ----------------------------------------------------------------------------
// VLQ source-map line decoder
// Decodes a base64 VLQ mappings string and reports the first mapped source
// line of each generated line.
// ----------------------------------------------------------------------------
//   channel   handshake            payload
//   in        in_valid / in_stall  func, character
//   out       out_valid / out_stall source_line, error, last
//
// One character is taken per cycle while in_stall is low. Each item passes
// through the token queue and then the back-end result register before its
// result sets out_valid. A result held by out_stall stops the back end;
// in_stall rises once the queue of QUEUE_DEPTH tokens is full.
// A source-line delta joins the running sum in the cycle after its field ends,
// and reset (asynchronous, active low) leaves the block ready at once.
// ----------------------------------------------------------------------------
`include "vlq_source_map_line_decoder_macros.svh"

module vlq_source_map_line_decoder #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [7:0]  character,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] source_line,
	output logic        error,
	output logic        last
);
	import vlqsm_pkg::*;

	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	token_t            front_tok;
	token_t            back_tok;
	logic              push;
	logic              full;
	logic              tok_valid;
	logic              tok_pop;
	logic [CNT_W-1:0]  q_count;

	assign in_stall = full;
	assign push     = in_valid && !full;

	vlqsm_front u_front (
		.func      (func),
		.character (character),
		.tok       (front_tok)
	);

	vlqsm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_tok),
		.full      (full),
		.pop       (tok_pop),
		.pop_valid (tok_valid),
		.pop_data  (back_tok),
		.count     (q_count)
	);

	vlqsm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.tok_valid   (tok_valid),
		.tok         (back_tok),
		.tok_pop     (tok_pop),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.source_line (source_line),
		.error       (error),
		.last        (last)
	);

	`VLQSM_ASSERT_NOW(a_error_only_on_end, out_valid && error,
		last && source_line == 32'd0, "error result without end marker or with a line value")
	`VLQSM_ASSERT_NOW(a_queue_bound, 1'b1, q_count <= CNT_W'(QUEUE_DEPTH),
		"token queue count exceeds its depth")
	`VLQSM_ASSERT_NEXT(a_push_lands, push, q_count != '0,
		"accepted transfer did not reach the token queue")

endmodule

// ===== sim/vlq_line_checker.sv =====
// ----------------------------------------------------------------------------
// VLQ source-map line decoder checker
// Watches both channels of the decoder, keeps its own model of the VLQ
// field decoding and the running source-line sum, and compares each result
// transfer with the oldest predicted line result.
// ----------------------------------------------------------------------------
package vlq_map_tb_pkg;

	localparam logic       FUNC_CHAR  = 1'b0;
	localparam logic       FUNC_END   = 1'b1;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_SEMI  = 8'h3B;
	localparam logic [5:0] DIGIT_CONT = 6'h20;

endpackage

module vlq_line_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        func,
	input  logic [7:0]  character,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] source_line,
	input  logic        error,
	input  logic        last,
	output int unsigned mismatches,
	output int unsigned outstanding
);
	import vlq_map_tb_pkg::*;

	typedef struct packed {
		logic        failed;
		logic [31:0] acc;
		logic [5:0]  shift;
		logic        cont;
		logic [2:0]  fields;
		logic [31:0] running;
		logic [31:0] first_line;
		logic        has_first;
	} map_state_t;

	typedef struct packed {
		logic [31:0] source_line;
		logic        error;
		logic        last;
	} line_result_t;

	map_state_t   map_st;
	line_result_t pending_lines[$];
	line_result_t want;
	line_result_t got;

	function automatic int digit_value(input logic [7:0] c);
		if (c >= "A" && c <= "Z") return int'(c) - int'("A");
		if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
		if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
		if (c == "+") return 62;
		if (c == "/") return 63;
		return -1;
	endfunction

	task automatic close_field();
		logic [31:0] mag;
		logic [31:0] val;
		mag = map_st.acc >> 1;
		val = map_st.acc[0] ? (32'd0 - mag) : mag;
		map_st.fields = map_st.fields + 3'd1;
		if (map_st.fields == 3'd3)
			map_st.running = map_st.running + val;
		if (map_st.fields == 3'd4 && !map_st.has_first && !map_st.running[31]) begin
			map_st.first_line = map_st.running + 32'd1;
			map_st.has_first  = 1'b1;
		end
		if (map_st.fields >= 3'd5)
			map_st.fields = 3'd0;
		map_st.acc   = 32'd0;
		map_st.shift = 6'd0;
	endtask

	task automatic decode_map_byte(input logic f, input logic [7:0] ch);
		int           d;
		line_result_t r;
		if (f == FUNC_END) begin
			if (map_st.cont || map_st.fields == 3'd2 || map_st.fields == 3'd3)
				map_st.failed = 1'b1;
			r.last        = 1'b1;
			r.error       = map_st.failed;
			r.source_line = (!map_st.failed && map_st.has_first) ? map_st.first_line : 32'd0;
			pending_lines.insert(pending_lines.size(), r);
			map_st = '0;
		end else if (!map_st.failed) begin
			d = digit_value(ch);
			if (map_st.cont || d >= 0) begin
				if (d < 0) begin
					map_st.failed = 1'b1;
				end else begin
					if (map_st.shift < 6'd32) begin
						map_st.acc   = map_st.acc | (32'(d & 31) << map_st.shift);
						map_st.shift = map_st.shift + 6'd5;
					end
					map_st.cont = d[5];
					if (!map_st.cont)
						close_field();
				end
			end else if (ch != CHAR_SEMI && ch != CHAR_COMMA) begin
				map_st.failed = 1'b1;
			end else if (map_st.fields == 3'd2 || map_st.fields == 3'd3) begin
				map_st.failed = 1'b1;
			end else begin
				map_st.fields = 3'd0;
				if (ch == CHAR_SEMI) begin
					r.last        = 1'b0;
					r.error       = 1'b0;
					r.source_line = map_st.has_first ? map_st.first_line : 32'd0;
					pending_lines.insert(pending_lines.size(), r);
					map_st.has_first  = 1'b0;
					map_st.first_line = 32'd0;
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_st = '0;
			pending_lines.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {source_line, error, last};
				if (pending_lines.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("checker: unexpected result line %0d error %0b last %0b",
							source_line, error, last);
				end else begin
					want = pending_lines.pop_front();
					if (got.source_line !== want.source_line || got.error !== want.error ||
						got.last !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("checker: expected %0d/%0b/%0b got %0d/%0b/%0b",
								want.source_line, want.error, want.last,
								got.source_line, got.error, got.last);
					end
				end
			end
			if (in_valid && !in_stall)
				decode_map_byte(func, character);
			outstanding <= pending_lines.size();
		end
	end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// VLQ source-map line decoder testbench
// Drives mappings strings into the decoder: a short directed set, then
// random well-formed and broken maps, with random gaps on the input and
// random stalls on the output. A checker beside the decoder predicts and
// compares every line result.
// ----------------------------------------------------------------------------
module testbench;

	import vlq_map_tb_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        func;
	logic [7:0]  character;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] source_line;
	logic        error;
	logic        last;
	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned items_sent;
	bit          burst_mode;

	vlq_source_map_line_decoder i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.character  (character),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.source_line(source_line),
		.error      (error),
		.last       (last)
	);

	vlq_line_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.character  (character),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.source_line(source_line),
		.error      (error),
		.last       (last),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(8 * 1000000);
		$display("testbench: done, errors");
		$finish;
	end

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] b64_char(input logic [5:0] d);
		if (d < 6'd26) return 8'("A") + 8'(d);
		if (d < 6'd52) return 8'("a") + 8'(d - 6'd26);
		if (d < 6'd62) return 8'("0") + 8'(d - 6'd52);
		if (d == 6'd62) return 8'("+");
		return 8'("/");
	endfunction

	function automatic longint random_delta();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7) return longint'($urandom_range(0, 15)) - 5;
		if (r < 9) return longint'($urandom_range(0, 2000)) - 1000;
		return longint'($signed($urandom));
	endfunction

	task automatic send_item(input logic f, input logic [7:0] ch);
		int gap;
		gap = burst_mode ? 0 : gap_length();
		if (gap > 0) begin
			@(negedge clk);
			in_valid  <= 1'b0;
			func      <= 1'($urandom);
			character <= 8'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		func      <= f;
		character <= ch;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(FUNC_CHAR, s[i]);
	endtask

	task automatic send_end();
		send_item(FUNC_END, 8'($urandom));
	endtask

	task automatic send_noise();
		string pool;
		pool = "AgB/+,;";
		if ($urandom_range(0, 1) == 0)
			send_item(FUNC_CHAR, 8'($urandom));
		else
			send_item(FUNC_CHAR, pool[$urandom_range(0, pool.len() - 1)]);
	endtask

	// Long fields pad with random digits to 8-12 digits; bits past 32 must be dropped.
	task automatic send_vlq(input longint value, input bit long_form);
		logic [33:0] v;
		logic [4:0]  d;
		int          natural_len;
		int          total_len;
		v = (value < 0) ? ((34'(-value) << 1) | 34'd1) : (34'(value) << 1);
		natural_len = 0;
		for (logic [33:0] t = v; natural_len == 0 || t != 0; t = t >> 5)
			natural_len++;
		total_len = long_form ? $urandom_range(8, 12) : natural_len;
		for (int i = 0; i < total_len; i++) begin
			if (i < natural_len) begin
				d = v[4:0];
				v = v >> 5;
			end else begin
				d = 5'($urandom);
			end
			send_item(FUNC_CHAR, b64_char({(i < total_len - 1), d} | 6'd0));
		end
	endtask

	task automatic send_segment(input int nfields);
		for (int i = 0; i < nfields; i++)
			send_vlq(random_delta(), $urandom_range(0, 19) == 0);
	endtask

	function automatic int pick_field_count();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2) return 1;
		if (r < 7) return 4;
		return 5;
	endfunction

	task automatic send_line();
		int nseg;
		int nf;
		bit prev_full;
		nseg = $urandom_range(0, 3);
		prev_full = 1'b0;
		for (int s = 0; s < nseg; s++) begin
			if (s > 0) begin
				if (!(prev_full && $urandom_range(0, 4) == 0))
					send_item(FUNC_CHAR, CHAR_COMMA);
				if ($urandom_range(0, 19) == 0)
					send_item(FUNC_CHAR, CHAR_COMMA);
			end
			nf = pick_field_count();
			send_segment(nf);
			prev_full = (nf == 5);
		end
	endtask

	task automatic send_well_formed_map();
		int nlines;
		nlines = $urandom_range(1, 4);
		for (int l = 0; l < nlines; l++) begin
			if (l > 0)
				send_item(FUNC_CHAR, CHAR_SEMI);
			send_line();
		end
		if ($urandom_range(0, 9) < 3)
			send_item(FUNC_CHAR, CHAR_SEMI);
		send_end();
	endtask

	task automatic send_broken_map();
		repeat ($urandom_range(0, 2)) begin
			send_line();
			send_item(FUNC_CHAR, CHAR_SEMI);
		end
		case ($urandom_range(0, 3))
			0: begin
				send_item(FUNC_CHAR, 8'($urandom));
			end
			1: begin
				send_segment($urandom_range(2, 3));
				case ($urandom_range(0, 2))
					0: send_item(FUNC_CHAR, CHAR_COMMA);
					1: send_item(FUNC_CHAR, CHAR_SEMI);
					default: send_end();
				endcase
			end
			2: begin
				repeat ($urandom_range(1, 3))
					send_item(FUNC_CHAR, b64_char(DIGIT_CONT | 6'($urandom_range(0, 31))));
			end
			default: begin
				send_item(FUNC_CHAR, b64_char(DIGIT_CONT | 6'($urandom_range(0, 31))));
				send_noise();
			end
		endcase
		repeat ($urandom_range(0, 3))
			send_noise();
		send_end();
	endtask

	initial begin
		int hold;
		int run;
		out_stall = 1'b0;
		forever begin
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 6);
			@(negedge clk);
			out_stall <= 1'b0;
			repeat (run - 1) @(negedge clk);
			hold = gap_length();
			if (hold > 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (hold - 1) @(negedge clk);
			end
		end
	end

	initial begin
		in_valid   = 1'b0;
		func       = FUNC_CHAR;
		character  = 8'd0;
		arst_n     = 1'b0;
		items_sent = 0;
		burst_mode = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty map, a closed segment followed directly by a new one, a negative
		// running line, short segments, an open VLQ and a bad character.
		send_end();
		send_text("AAAAAAACA;");
		send_text("AA/BA;");
		send_end();
		send_text("AAC");
		send_end();
		send_text("g");
		send_end();
		send_text("!;");
		send_end();

		while (items_sent < 1830) begin
			burst_mode = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 4) == 0)
				send_broken_map();
			else
				send_well_formed_map();
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (16) @(negedge clk);
		if (mismatches == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/vlqsm_pkg.sv
hdl/vlqsm_front.sv
hdl/vlqsm_queue.sv
hdl/vlqsm_back.sv
hdl/vlq_source_map_line_decoder.sv
sim/vlq_line_checker.sv
sim/testbench.sv
